// ===== rtl/bb3_pkg.sv =====
package bb3_pkg;

	// one RGB pixel, red in the low byte
	typedef logic [23:0] pixel_t;

	// configuration register indexes
	typedef logic [0:0] cfg_index_t;
	localparam cfg_index_t REG_FRAME_WIDTH  = 1'b0;
	localparam cfg_index_t REG_FRAME_HEIGHT = 1'b1;

	localparam int CFG_DATA_W    = 12;
	localparam int WIDTH_RESET   = 1280;
	localparam int HEIGHT_RESET  = 720;
	localparam int DIM_MIN       = 3;

	// floor(s / 9) for s <= 2295 equals (s * 7282) >> 16
	localparam int          SUM_W      = 12;
	localparam int          RECIP_W    = 13;
	localparam logic [12:0] RECIP9     = 13'd7282;
	localparam int          RECIP_SH   = 16;

	// result buffer depth, bounds the results in flight
	localparam int OUT_DEPTH = 8;

	// per-item control carried down the pipeline
	typedef struct packed {
		logic emit;
		logic first_col;
		logic interior;
		logic eof;
	} item_ctl_t;

	// one result word
	typedef struct packed {
		logic   eof;
		pixel_t px;
	} result_t;

endpackage

// ===== rtl/bb3_line_store.sv =====
module bb3_line_store
	import bb3_pkg::*;
#(
	parameter int DEPTH = 2048,
	parameter int AW    = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_col,
	input  logic [AW-1:0] last_col,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_col,
	input  pixel_t        wr_px,
	output pixel_t        up1,
	output pixel_t        up2,
	output pixel_t        lbw
);

	// one row up and two rows up
	pixel_t la_mem [DEPTH];
	pixel_t lb_mem [DEPTH];

	pixel_t up1_q;
	pixel_t up2_q;
	pixel_t lbw_q;
	pixel_t fwd_px_q;
	logic   fwd_q;

	// read on accept, write back in the cycle after
	always_ff @(posedge clk) begin
		if (rd_en) begin
			up1_q    <= la_mem[rd_col];
			up2_q    <= lb_mem[rd_col];
			lbw_q    <= lb_mem[last_col];
			fwd_px_q <= up1_q;
		end
		if (wr_en) begin
			la_mem[wr_col] <= wr_px;
			lb_mem[wr_col] <= up1_q;
		end
	end

	// last-column read collides with the write of the item ahead
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (rd_en) begin
			fwd_q <= wr_en && (wr_col == last_col);
		end
	end

	assign up1 = up1_q;
	assign up2 = up2_q;
	assign lbw = fwd_q ? fwd_px_q : lbw_q;

endmodule

// ===== rtl/bb3_window.sv =====
module bb3_window
	import bb3_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      valid_s1,
	input  item_ctl_t ctl_s1,
	input  pixel_t    px_s1,
	input  pixel_t    up1,
	input  pixel_t    up2,
	input  pixel_t    lbw,
	output logic      push,
	output result_t   push_data
);

	// window as three column sums per channel plus the center pixel
	logic [2:0][9:0]       cs0_q, cs1_q, cs2_q;
	logic [2:0][9:0]       cs_new;
	pixel_t                prev_up1_q;

	logic                  valid_s2, valid_s3, valid_s4;
	item_ctl_t             ctl_s2, ctl_s3, ctl_s4;
	pixel_t                lbw_s2, lbw_s3, lbw_s4;
	pixel_t                ctr_s2, ctr_s3, ctr_s4;
	logic [2:0][SUM_W-1:0] sum_s3;
	logic [2:0][SUM_W-1:0] sum_c;
	pixel_t                quot_s4;
	pixel_t                quot_c;
	logic [SUM_W+RECIP_W-1:0] prod [3];

	// new column sum from the incoming column
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cs_new[i] = 10'(up2[8*i +: 8]) + 10'(up1[8*i +: 8]) + 10'(px_s1[8*i +: 8]);
		end
	end

	// nine-term sum per channel
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum_c[i] = SUM_W'(cs0_q[i]) + SUM_W'(cs1_q[i]) + SUM_W'(cs2_q[i]);
		end
	end

	// divide by nine through the reciprocal
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod[i] = (SUM_W+RECIP_W)'(sum_s3[i]) * (SUM_W+RECIP_W)'(RECIP9);
			quot_c[8*i +: 8] = prod[i][RECIP_SH +: 8];
		end
	end

	// window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs0_q      <= '0;
			cs1_q      <= '0;
			cs2_q      <= '0;
			prev_up1_q <= '0;
		end else if (valid_s1) begin
			cs0_q      <= cs1_q;
			cs1_q      <= cs2_q;
			cs2_q      <= cs_new;
			prev_up1_q <= up1;
		end
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		ctl_s2  <= ctl_s1;
		lbw_s2  <= lbw;
		ctr_s2  <= prev_up1_q;
		ctl_s3  <= ctl_s2;
		lbw_s3  <= lbw_s2;
		ctr_s3  <= ctr_s2;
		sum_s3  <= sum_c;
		ctl_s4  <= ctl_s3;
		lbw_s4  <= lbw_s3;
		ctr_s4  <= ctr_s3;
		quot_s4 <= quot_c;
	end

	// pick border, blur or first-column value
	always_comb begin
		push_data.eof = ctl_s4.eof && ctl_s4.first_col;
		if (ctl_s4.first_col) begin
			push_data.px = lbw_s4;
		end else if (ctl_s4.interior) begin
			push_data.px = quot_s4;
		end else begin
			push_data.px = ctr_s4;
		end
	end

	assign push = valid_s4 && ctl_s4.emit;

endmodule

// ===== rtl/bb3_out_fifo.sv =====
module bb3_out_fifo
	import bb3_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    m_axis_tvalid,
	input  logic    m_axis_tready,
	output pixel_t  m_axis_tdata,
	output logic    m_axis_tlast
);

	localparam int PTR_W = $clog2(OUT_DEPTH);
	localparam int CNT_W = $clog2(OUT_DEPTH + 1);

	result_t            buf_q [OUT_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               pop;

	assign pop = m_axis_tvalid && m_axis_tready;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign m_axis_tvalid = (count_q != '0);
	assign m_axis_tdata  = buf_q[rd_ptr_q].px;
	assign m_axis_tlast  = buf_q[rd_ptr_q].eof;

endmodule

// ===== rtl/box_blur_3x3_rgb_stream.sv =====
// 3x3 box blur over an RGB24 raster stream with two line stores.
// Throughput: one word per cycle; ready drops only when eight results are
// outstanding in the pipeline and the output buffer together.
// A result belongs to the pixel frame_width + 1 words back; once the word
// that releases it is accepted it passes stages s1 to s4 and the buffer.
// Reset clears position, pending count, window and buffer; width resets to
// 1280, height to 720; line store contents are left as they are.
module box_blur_3x3_rgb_stream
	import bb3_pkg::*;
#(
	parameter int MAX_WIDTH  = 2048,
	parameter int MAX_HEIGHT = 2048
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [23:0]           s_axis_tdata,  // red_in, green_in, blue_in
	input  logic                  s_axis_tuser,  // filler
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [23:0]           m_axis_tdata,  // red_out, green_out, blue_out
	output logic                  m_axis_tlast,  // end_of_frame
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  cfg_index_t            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int PW = $clog2(MAX_WIDTH + 2);
	localparam int UW = $clog2(OUT_DEPTH + 1);
	localparam int W_RST = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
	localparam int H_RST = (HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RESET;

	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [CW-1:0] last_col;
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [PW-1:0] pend_q;
	logic [UW-1:0] used_q;

	logic          accept;
	logic          pop;
	pixel_t        px_in;
	item_ctl_t     ctl_in;
	logic [WW-1:0] col_inc;
	logic [HW-1:0] row_inc;

	logic          valid_s1;
	logic [CW-1:0] col_s1;
	pixel_t        px_s1;
	item_ctl_t     ctl_s1;

	pixel_t        up1, up2, lbw;
	logic          push;
	result_t       push_data;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (used_q < UW'(OUT_DEPTH));
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign last_col      = CW'(width_q - WW'(1));

	// configuration, saturated into range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(W_RST);
			height_q <= HW'(H_RST);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH: begin
					if (cfg_data < CFG_DATA_W'(DIM_MIN)) begin
						width_q <= WW'(DIM_MIN);
					end else if (32'(cfg_data) > MAX_WIDTH) begin
						width_q <= WW'(MAX_WIDTH);
					end else begin
						width_q <= WW'(cfg_data);
					end
				end
				REG_FRAME_HEIGHT: begin
					if (cfg_data < CFG_DATA_W'(DIM_MIN)) begin
						height_q <= HW'(DIM_MIN);
					end else if (32'(cfg_data) > MAX_HEIGHT) begin
						height_q <= HW'(MAX_HEIGHT);
					end else begin
						height_q <= HW'(cfg_data);
					end
				end
				default: begin
				end
			endcase
		end
	end

	// classify the incoming word
	always_comb begin
		px_in            = s_axis_tuser ? '0 : s_axis_tdata;
		col_inc          = WW'(col_q) + WW'(1);
		row_inc          = HW'(row_q) + HW'(1);
		ctl_in.first_col = (col_q == '0);
		ctl_in.eof       = (row_q == RW'(1));
		ctl_in.interior  = (row_q >= RW'(2)) && (HW'(row_q) < height_q)
		                && (col_q >= CW'(2)) && (WW'(col_q) < width_q);
		if (!s_axis_tuser) begin
			ctl_in.emit = (pend_q >= PW'(width_q) + PW'(1));
		end else begin
			ctl_in.emit = (pend_q != '0);
		end
	end

	// raster position, pending count and result credits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q  <= '0;
			row_q  <= '0;
			pend_q <= '0;
			used_q <= '0;
		end else begin
			if (accept) begin
				if (col_inc >= width_q) begin
					col_q <= '0;
					row_q <= (row_inc >= height_q) ? '0 : RW'(row_inc);
				end else begin
					col_q <= CW'(col_inc);
				end
				if (!s_axis_tuser && !ctl_in.emit) begin
					pend_q <= pend_q + PW'(1);
				end else if (s_axis_tuser && ctl_in.emit) begin
					pend_q <= pend_q - PW'(1);
				end
			end
			if ((accept && ctl_in.emit) && !pop) begin
				used_q <= used_q + UW'(1);
			end else if (!(accept && ctl_in.emit) && pop) begin
				used_q <= used_q - UW'(1);
			end
		end
	end

	// first stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1 <= col_q;
			px_s1  <= px_in;
			ctl_s1 <= ctl_in;
		end
	end

	bb3_line_store #(
		.DEPTH (MAX_WIDTH),
		.AW    (CW)
	) u_line_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (accept),
		.rd_col   (col_q),
		.last_col (last_col),
		.wr_en    (valid_s1),
		.wr_col   (col_s1),
		.wr_px    (px_s1),
		.up1      (up1),
		.up2      (up2),
		.lbw      (lbw)
	);

	bb3_window u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.ctl_s1    (ctl_s1),
		.px_s1     (px_s1),
		.up1       (up1),
		.up2       (up2),
		.lbw       (lbw),
		.push      (push),
		.push_data (push_data)
	);

	bb3_out_fifo u_out_fifo (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.push_data     (push_data),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule
